### rtl/core/shs_pkg.sv
// Shared types, constants and sigma functions for the SHA-256 stream hasher.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package shs_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } out_item_t;

  // 16 big-endian message words, index 0 holds bytes 0..3
  typedef logic [15:0][31:0] block_t;
  // eight 32-bit words, index 0 is a / H0
  typedef logic [7:0][31:0]  chain_t;

  typedef struct packed {
    logic start;
    logic rearm;
  } comp_ctl_t;

  typedef struct packed {
    logic done;
  } comp_sts_t;

  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LenByte   = 6'd56;
  localparam logic [2:0] LastWord  = 3'd7;
  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [63:0] BytBits  = 64'd8;

  localparam chain_t InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/shs_round.sv
// One SHA-256 compression round: the shared arithmetic unit of the block.
// Depends on shs_pkg (chain_t, big sigma functions).
`default_nettype none

module shs_round (
  input  shs_pkg::chain_t vars_in,
  input  logic [31:0]     w,
  input  logic [31:0]     k,
  output shs_pkg::chain_t vars_out
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
  assign maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^
               (vars_in[1] & vars_in[2]);
  assign t1  = vars_in[7] + shs_pkg::bsig1(vars_in[4]) + ch + k + w;
  assign t2  = shs_pkg::bsig0(vars_in[0]) + maj;

  always_comb begin
    vars_out[0] = t1 + t2;
    vars_out[1] = vars_in[0];
    vars_out[2] = vars_in[1];
    vars_out[3] = vars_in[2];
    vars_out[4] = vars_in[3] + t1;
    vars_out[5] = vars_in[4];
    vars_out[6] = vars_in[5];
    vars_out[7] = vars_in[6];
  end

endmodule

`default_nettype wire

### rtl/core/shs_comp.sv
// Block compressor: chaining words, 16-word schedule window and round sequencer.
// Depends on shs_pkg and shs_round.
`default_nettype none

module shs_comp (
  input  logic              clk,
  input  logic              rst,
  input  shs_pkg::comp_ctl_t ctl,
  input  shs_pkg::block_t   blk,
  output shs_pkg::comp_sts_t sts,
  output shs_pkg::chain_t   chain
);

  logic            busy;
  logic            fin;
  logic            done;
  logic [5:0]      rnd;
  shs_pkg::block_t win;
  shs_pkg::block_t win_next;
  shs_pkg::chain_t vars;
  shs_pkg::chain_t vars_next;
  logic [31:0]     w_new;

  shs_round u_round (
    .vars_in  (vars),
    .w        (win[0]),
    .k        (shs_pkg::RoundK[rnd]),
    .vars_out (vars_next)
  );

  // window holds w[t..t+15]; w[t+16] enters at the top
  assign w_new = shs_pkg::ssig1(win[14]) + win[9] + shs_pkg::ssig0(win[1]) + win[0];

  always_comb begin
    for (int i = 0; i < 15; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[15] = w_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      done  <= 1'b0;
      rnd   <= '0;
      chain <= shs_pkg::InitH;
    end else begin
      done <= 1'b0;
      if (ctl.rearm) begin
        chain <= shs_pkg::InitH;
      end
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == shs_pkg::LastRound) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      win  <= blk;
      vars <= chain;
    end else if (busy) begin
      win  <= win_next;
      vars <= vars_next;
    end
  end

  assign sts.done = done;

endmodule

`default_nettype wire

### rtl/core/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: block buffer, padding sequencer, digest output.
// Depends on shs_pkg and shs_comp (which holds shs_round).
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item  (shs_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_item (shs_pkg::out_item_t)
//
// Bytes are taken only while the sequencer is idle; every 64th byte starts a compression
// that runs 64 rounds through the one round unit, and no new byte is taken until it ends.
// End of message: a pad state and one compression; when the length does not fit, a
// length state and a second compression follow; then 8 output transfers.
// in_stall is high whenever the sequencer is not idle. Synchronous reset restores
// the initial hash values and clears the fill and bit counts; the buffer is not reset.
`default_nettype none

module sha256_stream_hasher_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  shs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output shs_pkg::out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_LEN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t              state;
  logic [5:0]          fill;
  logic [63:0]         bitcnt;
  logic                end_pend;
  logic                pad_mark;
  logic                last_blk;
  logic [2:0]          wcnt;
  shs_pkg::comp_ctl_t  ctl;
  shs_pkg::comp_sts_t  sts;
  shs_pkg::chain_t     chain;
  shs_pkg::block_t     blk;
  logic                in_acc;
  logic                out_acc;
  logic                wr_byte;
  logic                pad_now;
  logic                len_now;
  logic                len_fits;

  shs_comp u_comp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .blk   (blk),
    .sts   (sts),
    .chain (chain)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign wr_byte  = in_acc && in_item.byte_present;
  assign pad_now  = (state == ST_PAD);
  assign len_now  = (state == ST_LEN);
  assign len_fits = (fill < shs_pkg::LenByte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      bitcnt   <= '0;
      end_pend <= 1'b0;
      pad_mark <= 1'b0;
      last_blk <= 1'b0;
      wcnt     <= '0;
      ctl      <= '0;
    end else begin
      ctl <= '0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_item.byte_present) begin
              bitcnt <= bitcnt + shs_pkg::BytBits;
              fill   <= fill + 6'd1;
            end
            if (in_item.byte_present && fill == shs_pkg::LastByte) begin
              ctl.start <= 1'b1;
              last_blk  <= 1'b0;
              end_pend  <= in_item.end_of_message;
              state     <= ST_COMP;
            end else if (in_item.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // marker, zeros and (if room) the length go in this cycle
          ctl.start <= 1'b1;
          pad_mark  <= 1'b1;
          end_pend  <= 1'b0;
          last_blk  <= len_fits;
          state     <= ST_COMP;
        end
        ST_LEN: begin
          ctl.start <= 1'b1;
          last_blk  <= 1'b1;
          state     <= ST_COMP;
        end
        ST_COMP: begin
          if (sts.done) begin
            if (last_blk) begin
              state <= ST_OUT;
            end else if (end_pend) begin
              state <= ST_PAD;
            end else if (pad_mark) begin
              state <= ST_LEN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            wcnt <= wcnt + 3'd1;
            if (wcnt == shs_pkg::LastWord) begin
              ctl.rearm <= 1'b1;
              fill      <= '0;
              bitcnt    <= '0;
              pad_mark  <= 1'b0;
              last_blk  <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // byte lanes, big-endian within each word
  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (wr_byte && fill == 6'(4 * w + b)) begin
          blk[w][8*(3-b) +: 8] <= in_item.message_byte;
        end else if (pad_now && fill == 6'(4 * w + b)) begin
          blk[w][8*(3-b) +: 8] <= shs_pkg::PadMark;
        end else if ((pad_now && fill < 6'(4 * w + b)) || len_now) begin
          blk[w][8*(3-b) +: 8] <= 8'h00;
        end
      end
    end
    if ((pad_now && len_fits) || len_now) begin
      blk[14] <= bitcnt[63:32];
      blk[15] <= bitcnt[31:0];
    end
  end

  assign out_valid            = (state == ST_OUT);
  assign out_item.digest_word = chain[wcnt];
  assign out_item.word_number = wcnt;
  assign out_item.final_word  = (wcnt == shs_pkg::LastWord);

endmodule

`default_nettype wire
